// ----- sv/srtf_schedule_simulator_macros.svh -----
`ifndef SRTF_SCHEDULE_SIMULATOR_MACROS_SVH
`define SRTF_SCHEDULE_SIMULATOR_MACROS_SVH

// check on every clock edge outside reset
`define SRTF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also covers the reset cycles
`define SRTF_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/srtf_pkg.sv -----
`timescale 1ns / 1ps

package srtf_pkg;

  localparam int MAX_PROCS  = 16;
  localparam int SLOT_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W      = $clog2(MAX_PROCS + 1);
  localparam int TIME_W     = 13;
  localparam int ARR_W      = 10;
  localparam int BURST_W    = 8;
  localparam int OUT_SLOT_W = 4;

  typedef logic [TIME_W-1:0]     time_t;
  typedef logic [ARR_W-1:0]      arr_t;
  typedef logic [BURST_W-1:0]    burst_t;
  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [OUT_SLOT_W-1:0] out_slot_t;

  // selection token passed down the cell row
  typedef struct packed {
    logic   found;
    burst_t best_rem;
    slot_t  best_slot;
    logic   nxt_valid;
    arr_t   nxt;
  } token_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic   clear;
    logic   load_en;
    logic   upd_en;
    slot_t  slot;
    arr_t   arr;
    burst_t burst;
    burst_t run;
    time_t  upd_time;
  } cell_cmd_t;

  typedef struct packed {
    arr_t   arr;
    burst_t burst;
    time_t  comp;
  } cell_info_t;

endpackage

// ----- sv/srtf_cell.sv -----
`timescale 1ns / 1ps

module srtf_cell (
  input  logic                clk,
  input  logic                rst,
  input  srtf_pkg::slot_t     idx,
  input  srtf_pkg::cell_cmd_t cmd,
  input  srtf_pkg::time_t     sim_time,
  input  srtf_pkg::token_t    tok_in,
  output srtf_pkg::token_t    tok_out,
  output srtf_pkg::cell_info_t info
);
  import srtf_pkg::*;

  logic   live;
  logic   done;
  arr_t   arr;
  burst_t burst;
  burst_t rem;
  time_t  comp;
  logic   elig;
  logic   arrived;
  logic   hit;
  token_t tok_next;

  assign hit     = (cmd.slot == idx);
  assign elig    = live && !done;
  assign arrived = (TIME_W'(arr) <= sim_time);

  always_comb begin
    tok_next = tok_in;
    if (elig && arrived && (!tok_in.found || rem < tok_in.best_rem)) begin
      tok_next.found     = 1'b1;
      tok_next.best_rem  = rem;
      tok_next.best_slot = idx;
    end
    if (elig && !arrived && (!tok_in.nxt_valid || arr < tok_in.nxt)) begin
      tok_next.nxt_valid = 1'b1;
      tok_next.nxt       = arr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      live <= 1'b0;
      done <= 1'b0;
    end else if (cmd.load_en && hit) begin
      live <= 1'b1;
      done <= 1'b0;
    end else if (cmd.upd_en && hit && rem == cmd.run) begin
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
    if (cmd.load_en && hit) begin
      arr   <= cmd.arr;
      burst <= cmd.burst;
      rem   <= cmd.burst;
    end else if (cmd.upd_en && hit) begin
      rem <= rem - cmd.run;
      if (rem == cmd.run) begin
        comp <= cmd.upd_time;
      end
    end
  end

  assign info = '{arr: arr, burst: burst, comp: comp};

endmodule

// ----- sv/srtf_schedule_simulator.sv -----
`timescale 1ns / 1ps

// shortest-remaining-time-first schedule simulator
// input channel (in_valid / in_ready): one request per process, arrive_at
//   and burst_len, stored in slot order; last_process starts the run.
//   requests beyond MAX_PROCS loaded slots are dropped. burst 0 counts as 1
// output channel (out_valid / out_ready): one result per loaded slot in slot
//   order, last_result set on the final slot
// each slot is a cell in a row; a selection token walks the row one cell per
//   cycle, and one scheduling round is a sweep then an apply step. a round runs
//   the chosen process up to its finish or the next arrival, so a set of n
//   processes needs at most 2n rounds; after the last round the results follow
//   one per cycle while the receiver takes them
// in_ready is low from the last request until the final result sits in the
//   output register
// when the receiver stalls, the output register holds its result and the
//   row waits; the next set may load while the final result is still pending
// reset empties all slots and returns to loading

module srtf_schedule_simulator (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  srtf_pkg::arr_t      arrive_at,
  input  srtf_pkg::burst_t    burst_len,
  input  logic                last_process,
  output logic                out_valid,
  input  logic                out_ready,
  output srtf_pkg::out_slot_t process_slot,
  output srtf_pkg::time_t     finish_tick,
  output srtf_pkg::time_t     turnaround_len,
  output srtf_pkg::time_t     wait_len,
  output logic                last_result
);
  import srtf_pkg::*;

  typedef enum logic [1:0] {
    S_LOAD,
    S_SWEEP,
    S_APPLY,
    S_EMIT
  } state_t;

  state_t     state;
  cnt_t       loaded_cnt;
  cnt_t       fin_cnt;
  time_t      sim_time;
  slot_t      sweep_cnt;
  slot_t      emit_idx;
  cell_cmd_t  cmd;
  token_t     tok [MAX_PROCS];
  cell_info_t info [MAX_PROCS];
  token_t     best;
  cell_info_t sel;
  time_t      gap;
  burst_t     run;
  logic       fin;
  time_t      new_t;
  logic       room;
  logic       emit_go;
  logic       emit_last;
  time_t      tat;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_PROCS; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        srtf_cell u_cell (
          .clk      (clk),
          .rst      (rst),
          .idx      (SLOT_W'(gi)),
          .cmd      (cmd),
          .sim_time (sim_time),
          .tok_in   ('0),
          .tok_out  (tok[gi]),
          .info     (info[gi])
        );
      end else begin : g_body
        srtf_cell u_cell (
          .clk      (clk),
          .rst      (rst),
          .idx      (SLOT_W'(gi)),
          .cmd      (cmd),
          .sim_time (sim_time),
          .tok_in   (tok[gi-1]),
          .tok_out  (tok[gi]),
          .info     (info[gi])
        );
      end
    end
  endgenerate

  assign best      = tok[MAX_PROCS-1];
  assign room      = (loaded_cnt < CNT_W'(MAX_PROCS));
  assign in_ready  = (state == S_LOAD);
  assign gap       = TIME_W'(best.nxt) - sim_time;
  assign run       = (!best.nxt_valid || TIME_W'(best.best_rem) <= gap) ?
                     best.best_rem : gap[BURST_W-1:0];
  assign fin       = (run == best.best_rem);
  assign new_t     = sim_time + TIME_W'(run);
  assign sel       = info[emit_idx];
  assign tat       = sel.comp - TIME_W'(sel.arr);
  assign emit_go   = !out_valid || out_ready;
  assign emit_last = ((CNT_W'(emit_idx) + CNT_W'(1)) == loaded_cnt);

  always_comb begin
    cmd          = '0;
    cmd.clear    = (state == S_EMIT) && emit_go && emit_last;
    cmd.load_en  = (state == S_LOAD) && in_valid && room;
    cmd.upd_en   = (state == S_APPLY) && best.found;
    cmd.slot     = (state == S_LOAD) ? loaded_cnt[SLOT_W-1:0] : best.best_slot;
    cmd.arr      = arrive_at;
    cmd.burst    = (burst_len == '0) ? BURST_W'(1) : burst_len;
    cmd.run      = run;
    cmd.upd_time = new_t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      loaded_cnt <= '0;
      fin_cnt    <= '0;
      sim_time   <= '0;
      sweep_cnt  <= '0;
      emit_idx   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (room) begin
              loaded_cnt <= loaded_cnt + CNT_W'(1);
            end
            if (last_process) begin
              state     <= S_SWEEP;
              sweep_cnt <= '0;
            end
          end
        end
        S_SWEEP: begin
          sweep_cnt <= sweep_cnt + SLOT_W'(1);
          if (sweep_cnt == SLOT_W'(MAX_PROCS - 1)) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          sweep_cnt <= '0;
          if (best.found) begin
            sim_time <= new_t;
            if (fin) begin
              fin_cnt <= fin_cnt + CNT_W'(1);
            end
          end else begin
            sim_time <= TIME_W'(best.nxt);
          end
          if (best.found && fin && ((fin_cnt + CNT_W'(1)) == loaded_cnt)) begin
            state    <= S_EMIT;
            emit_idx <= '0;
          end else begin
            state <= S_SWEEP;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid      <= 1'b1;
            process_slot   <= OUT_SLOT_W'(emit_idx);
            finish_tick    <= sel.comp;
            turnaround_len <= tat;
            wait_len       <= tat - TIME_W'(sel.burst);
            last_result    <= emit_last;
            emit_idx       <= emit_idx + SLOT_W'(1);
            if (emit_last) begin
              state      <= S_LOAD;
              loaded_cnt <= '0;
              fin_cnt    <= '0;
              sim_time   <= '0;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// ----- sv/srtf_checker.sv -----
`timescale 1ns / 1ps

`include "srtf_schedule_simulator_macros.svh"

module srtf_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input srtf_pkg::arr_t      arrive_at,
  input srtf_pkg::burst_t    burst_len,
  input logic                last_process,
  input logic                out_valid,
  input logic                out_ready,
  input srtf_pkg::out_slot_t process_slot,
  input srtf_pkg::time_t     finish_tick,
  input srtf_pkg::time_t     turnaround_len,
  input srtf_pkg::time_t     wait_len,
  input logic                last_result
);
  import srtf_pkg::*;

  // a set is closed by its last request
  `SRTF_ASSERT(a_run_blocks_input, in_valid && in_ready && last_process |=> !in_ready, "request taken after last process")

  // stalled result holds
  `SRTF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(process_slot) && $stable(finish_tick), "stalled result changed")

  // with no set running, nothing follows the final result
  `SRTF_ASSERT(a_no_extra, out_valid && out_ready && last_result && in_ready |=> !out_valid, "result after final slot")

  // every process runs at least one unit after arriving
  `SRTF_ASSERT(a_times, out_valid |-> turnaround_len > wait_len && finish_tick >= turnaround_len, "inconsistent result times")

  // reset returns to loading with no result pending
  `SRTF_ASSERT_RST(a_reset, rst |=> in_ready && !out_valid, "bad state after reset")

endmodule

bind srtf_schedule_simulator srtf_checker u_chk (.*);
